// ===== hdl/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg
// shared constants and types for the linear probe hash tracker
// ----------------------------------------------------------------------------
package lpht_pkg;

   localparam int MAX_SLOTS_DEF = 1024;
   localparam int KEY_BYTES_DEF = 16;
   localparam int CFG_W         = 11;
   localparam logic [CFG_W-1:0] SLOT_COUNT_RST = 11'd1024;

   typedef enum logic [1:0] {
      KIND_LOOKUP  = 2'd0,
      KIND_UPDATE  = 2'd1,
      KIND_CLEANUP = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOTFOUND = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MARK_EMPTY = 2'd0,
      MARK_LIVE  = 2'd1,
      MARK_TOMB  = 2'd2
   } mark_type;

   localparam logic [31:0] HASH_SEED = 32'd5381;
   localparam int          HASH_SHIFT = 5;

endpackage

// ===== hdl/lpht_hash.sv =====
// ----------------------------------------------------------------------------
// lpht_hash
// cuts the key at its first zero byte, hashes one character per cycle and
// reduces the hash modulo the slot count by restoring subtraction
// ----------------------------------------------------------------------------
module lpht_hash
   import lpht_pkg::*;
#(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF,
   parameter int KEY_BYTES = KEY_BYTES_DEF,
   localparam int IW = $clog2(MAX_SLOTS)
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [63:0]    key_high,
   input  logic [63:0]    key_low,
   input  logic [16:0]    slots,
   output logic           done,
   output logic [127:0]   key_norm,
   output logic [IW-1:0]  home
);

   localparam int CW = $clog2(KEY_BYTES + 1);

   typedef enum logic [1:0] {H_IDLE, H_HASH, H_MOD, H_DONE} hstate_type;

   hstate_type    state_ff;
   logic [127:0]  key_ff;
   logic [127:0]  norm_ff;
   logic [31:0]   h_ff;
   logic [CW-1:0] cnt_ff;
   logic [5:0]    bit_ff;
   logic [16:0]   rem_ff;
   logic          stop_ff;

   logic [7:0]    ch;
   logic [17:0]   trial;

   assign ch    = key_ff[127:120];
   assign trial = {rem_ff, h_ff[31]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
      end else begin
         unique case (state_ff)
            H_IDLE: begin
               if (start) begin
                  key_ff   <= {key_high, key_low};
                  norm_ff  <= '0;
                  h_ff     <= HASH_SEED;
                  cnt_ff   <= '0;
                  stop_ff  <= 1'b0;
                  state_ff <= H_HASH;
               end
            end
            H_HASH: begin
               if (cnt_ff == CW'(KEY_BYTES) || stop_ff || ch == 8'd0) begin
                  rem_ff   <= '0;
                  bit_ff   <= '0;
                  state_ff <= H_MOD;
               end else begin
                  h_ff    <= (h_ff << HASH_SHIFT) + h_ff + {24'd0, ch};
                  norm_ff <= norm_ff | ({ch, 120'd0} >> {cnt_ff, 3'b000});
                  key_ff  <= key_ff << 8;
                  cnt_ff  <= cnt_ff + 1'b1;
               end
            end
            H_MOD: begin
               if (trial >= {1'b0, slots}) begin
                  rem_ff <= 17'(trial - {1'b0, slots});
               end else begin
                  rem_ff <= trial[16:0];
               end
               h_ff   <= h_ff << 1;
               bit_ff <= bit_ff + 1'b1;
               if (bit_ff == 6'd31) begin
                  state_ff <= H_DONE;
               end
            end
            H_DONE: begin
               state_ff <= H_IDLE;
            end
            default: state_ff <= H_IDLE;
         endcase
      end
   end

   assign done     = (state_ff == H_DONE);
   assign key_norm = norm_ff;
   assign home     = rem_ff[IW-1:0];

endmodule

// ===== hdl/linear_probe_hash_tracker.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_tracker
// open-addressing table keyed by a text address, lookup, update and sweep
// ----------------------------------------------------------------------------
// usage:
//   req_ carries one command per transfer: kind in tuser, the key, times,
//   payload and current time in tdata. rsp_ returns exactly one result per
//   command. csr_ writes the slot count and clears the whole table.
//   one command is worked at a time. lookup and update hash the key up
//   to its length, reduce the hash modulo the slot count, then read,
//   wait and decide for each slot on the probe path, then load the
//   output register.
//   a cleanup sweep reads, waits and decides on every slot of the slot
//   count, then loads the output register.
//   after reset a clearing pass over MAX_SLOTS slots empties the slot marks;
//   the same pass runs after every csr_ write. no command is taken meanwhile.
//   the result sits in an output register; req_ takes the next command while
//   it waits, and a stalled receiver holds it until rsp_tready.
// ----------------------------------------------------------------------------
module linear_probe_hash_tracker
   import lpht_pkg::*;
#(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF,
   parameter int KEY_BYTES = KEY_BYTES_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // key_high, key_low, block_end_in, first_try_in, payload_in, now_time
   input  logic [255:0]  req_tdata,
   // kind
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // block_end_out, first_try_out, payload_out, freed_count, zero fill
   output logic [111:0]  rsp_tdata,
   // status
   output logic [1:0]    rsp_tuser,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [10:0]   csr_data
);

   localparam int IW = $clog2(MAX_SLOTS);
   localparam int DW = 128 + 96;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_HASH, S_READ, S_WAIT, S_DECIDE, S_RESP
   } state_type;

   state_type     state_ff;
   logic [10:0]   slot_count_ff;
   logic [IW-1:0] idx_ff;
   logic [16:0]   k_ff;
   logic [1:0]    kind_ff;
   logic [127:0]  key_ff;
   logic [95:0]   rec_ff;
   logic [31:0]   now_ff;
   logic          have_tomb_ff;
   logic [IW-1:0] tomb_ff;
   logic [10:0]   freed_ff;
   logic [10:0]   live_ff;
   logic [1:0]    res_stat_ff;
   logic [95:0]   res_rec_ff;
   logic [10:0]   res_freed_ff;
   logic          ovalid_ff;
   logic [1:0]    ostat_ff;
   logic [95:0]   orec_ff;
   logic [10:0]   ofreed_ff;

   logic [1:0]    mark_mem [MAX_SLOTS];
   logic [DW-1:0] data_mem [MAX_SLOTS];
   logic [1:0]    mark_rd_ff;
   logic [DW-1:0] data_rd_ff;

   logic          mwe;
   logic [IW-1:0] maddr;
   logic [1:0]    mwmark;
   logic          dwe;
   logic [DW-1:0] dwdata;

   logic [16:0]   n_eff;
   logic          hstart;
   logic          hdone;
   logic [127:0]  hkey;
   logic [IW-1:0] hhome;
   logic [IW-1:0] idx_next;
   logic          key_hit;
   logic          expired;
   logic [31:0]   be_rd;
   logic [31:0]   ft_rd;

   always_comb begin
      if (slot_count_ff == 11'd0) begin
         n_eff = 17'd1;
      end else if (17'(slot_count_ff) > 17'(MAX_SLOTS)) begin
         n_eff = 17'(MAX_SLOTS);
      end else begin
         n_eff = 17'(slot_count_ff);
      end
   end

   assign hstart = req_tvalid && req_tready &&
                   (req_tuser == KIND_LOOKUP || req_tuser == KIND_UPDATE);

   lpht_hash #(.MAX_SLOTS(MAX_SLOTS), .KEY_BYTES(KEY_BYTES)) u_hash (
      .clock    (clock),
      .reset    (reset),
      .start    (hstart),
      .key_high (req_tdata[63:0]),
      .key_low  (req_tdata[127:64]),
      .slots    (n_eff),
      .done     (hdone),
      .key_norm (hkey),
      .home     (hhome)
   );

   assign idx_next = (17'(idx_ff) + 17'd1 == n_eff) ? '0 : IW'(idx_ff + 1'b1);
   assign be_rd    = data_rd_ff[159:128];
   assign ft_rd    = data_rd_ff[191:160];
   assign key_hit  = (mark_rd_ff == MARK_LIVE) && (data_rd_ff[127:0] == key_ff);
   assign expired  = (be_rd != 32'd0 && be_rd <= now_ff)
                  || (be_rd == 32'd0 && ft_rd != 32'd0 && ft_rd < now_ff);

   // memory write selection
   always_comb begin
      mwe    = 1'b0;
      dwe    = 1'b0;
      maddr  = idx_ff;
      mwmark = MARK_LIVE;
      dwdata = {rec_ff, key_ff};
      if (state_ff == S_CLEAR) begin
         mwe    = 1'b1;
         mwmark = MARK_EMPTY;
      end else if (state_ff == S_DECIDE) begin
         if (kind_ff == KIND_CLEANUP) begin
            if (mark_rd_ff == MARK_LIVE && expired) begin
               mwe    = 1'b1;
               mwmark = MARK_TOMB;
            end
         end else if (kind_ff == KIND_UPDATE) begin
            if (key_hit) begin
               dwe = 1'b1;
            end else if (mark_rd_ff == MARK_EMPTY ||
                         k_ff + 17'd1 == n_eff) begin
               if (have_tomb_ff) begin
                  maddr = tomb_ff;
                  mwe   = 1'b1;
                  dwe   = 1'b1;
               end else if (mark_rd_ff == MARK_EMPTY) begin
                  mwe = 1'b1;
                  dwe = 1'b1;
               end else if (mark_rd_ff == MARK_TOMB) begin
                  mwe = 1'b1;
                  dwe = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mwe) begin
         mark_mem[maddr] <= mwmark;
      end
      if (dwe) begin
         data_mem[maddr] <= dwdata;
      end
      mark_rd_ff <= mark_mem[idx_ff];
      data_rd_ff <= data_mem[idx_ff];
   end

   assign req_tready = (state_ff == S_IDLE) && !csr_valid;
   assign csr_ready  = (state_ff == S_IDLE) && !ovalid_ff;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tuser  = ostat_ff;
   assign rsp_tdata  = {5'd0, ofreed_ff, orec_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         slot_count_ff <= SLOT_COUNT_RST;
         idx_ff        <= '0;
         live_ff       <= '0;
         ovalid_ff     <= 1'b0;
      end else begin
         if (state_ff == S_RESP && (!ovalid_ff || rsp_tready)) begin
            ovalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            ovalid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               if (idx_ff == IW'(MAX_SLOTS - 1)) begin
                  idx_ff   <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  idx_ff <= IW'(idx_ff + 1'b1);
               end
            end
            S_IDLE: begin
               if (csr_valid && csr_ready) begin
                  slot_count_ff <= csr_data;
                  live_ff       <= '0;
                  idx_ff        <= '0;
                  state_ff      <= S_CLEAR;
               end else if (req_tvalid && req_tready) begin
                  kind_ff      <= req_tuser;
                  rec_ff       <= req_tdata[223:128];
                  now_ff       <= req_tdata[255:224];
                  have_tomb_ff <= 1'b0;
                  freed_ff     <= '0;
                  k_ff         <= '0;
                  idx_ff       <= '0;
                  case (req_tuser)
                     KIND_LOOKUP, KIND_UPDATE: state_ff <= S_HASH;
                     KIND_CLEANUP: state_ff <= S_READ;
                     default: begin
                        res_stat_ff  <= ST_OK;
                        res_rec_ff   <= '0;
                        res_freed_ff <= '0;
                        state_ff     <= S_RESP;
                     end
                  endcase
               end
            end
            S_HASH: begin
               if (hdone) begin
                  key_ff   <= hkey;
                  idx_ff   <= hhome;
                  state_ff <= S_READ;
               end
            end
            S_READ: state_ff <= S_WAIT;
            S_WAIT: state_ff <= S_DECIDE;
            S_DECIDE: begin
               k_ff   <= k_ff + 17'd1;
               idx_ff <= idx_next;
               if (kind_ff == KIND_CLEANUP) begin
                  if (mark_rd_ff == MARK_LIVE && expired) begin
                     freed_ff <= freed_ff + 11'd1;
                     live_ff  <= live_ff - 11'd1;
                  end
                  if (k_ff + 17'd1 == n_eff) begin
                     res_stat_ff  <= ST_OK;
                     res_rec_ff   <= '0;
                     res_freed_ff <= freed_ff
                        + 11'(mark_rd_ff == MARK_LIVE && expired);
                     state_ff     <= S_RESP;
                  end else begin
                     state_ff <= S_READ;
                  end
               end else if (key_hit) begin
                  res_stat_ff  <= ST_OK;
                  res_rec_ff   <= (kind_ff == KIND_LOOKUP) ? data_rd_ff[223:128] : 96'd0;
                  res_freed_ff <= '0;
                  state_ff     <= S_RESP;
               end else if (mark_rd_ff == MARK_EMPTY || k_ff + 17'd1 == n_eff) begin
                  res_rec_ff   <= '0;
                  res_freed_ff <= '0;
                  state_ff     <= S_RESP;
                  if (kind_ff == KIND_LOOKUP) begin
                     res_stat_ff <= ST_NOTFOUND;
                  end else if (mwe) begin
                     res_stat_ff <= ST_OK;
                     live_ff     <= live_ff + 11'd1;
                  end else begin
                     res_stat_ff <= ST_FULL;
                  end
               end else begin
                  state_ff <= S_READ;
                  if (mark_rd_ff == MARK_TOMB && !have_tomb_ff) begin
                     have_tomb_ff <= 1'b1;
                     tomb_ff      <= idx_ff;
                  end
               end
            end
            S_RESP: begin
               if (!ovalid_ff || rsp_tready) begin
                  ostat_ff  <= res_stat_ff;
                  orec_ff   <= res_rec_ff;
                  ofreed_ff <= res_freed_ff;
                  state_ff  <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== hdl/lpht_checker.sv =====
// ----------------------------------------------------------------------------
// lpht_checker
// port-level checks for the linear probe hash tracker
// ----------------------------------------------------------------------------
module lpht_checker
   import lpht_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          req_tvalid,
   input logic          req_tready,
   input logic          rsp_tvalid,
   input logic          rsp_tready,
   input logic [111:0]  rsp_tdata,
   input logic [1:0]    rsp_tuser,
   input logic          csr_valid,
   input logic          csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= ST_FULL)
      else $error("bad status code");

   a_no_req_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second transfer before result");

   a_cfg_idle: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |-> !rsp_tvalid)
      else $error("config taken with result pending");

endmodule

bind linear_probe_hash_tracker lpht_checker u_lpht_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);
